### rtl/mbcrtc_pkg.sv
package mbcrtc_pkg;

    // Bus operation codes
    localparam logic [2:0] OP_SELECT = 3'd0;
    localparam logic [2:0] OP_ENABLE = 3'd1;
    localparam logic [2:0] OP_LATCH  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_TICK   = 3'd5;

    // Clock register indexes
    localparam logic [2:0] REG_SECONDS = 3'd0;
    localparam logic [2:0] REG_MINUTES = 3'd1;
    localparam logic [2:0] REG_HOURS   = 3'd2;
    localparam logic [2:0] REG_DAYS    = 3'd3;
    localparam logic [2:0] REG_DAYCTL  = 3'd4;
    localparam logic [7:0] NUM_REGS    = 8'd5;

    localparam logic [7:0] MASK_SECONDS = 8'h3F;
    localparam logic [7:0] MASK_MINUTES = 8'h3F;
    localparam logic [7:0] MASK_HOURS   = 8'h1F;
    localparam logic [7:0] MASK_DAYS    = 8'hFF;
    localparam logic [7:0] MASK_DAYCTL  = 8'hC1;
    localparam logic [7:0] READ_DISABLED = 8'hFF;

    localparam logic [6:0] SECS_PER_MIN  = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       select_error;
    } rsp_t;

    // Time of day in mixed radix; day is nine bits
    typedef struct packed {
        logic [8:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } rtc_time_t;

    // Control from the command stage to the time counter
    typedef struct packed {
        logic       tick;
        logic       write;
        logic [2:0] sel;
        logic [7:0] data;
    } time_ctrl_t;

    // Status from the time counter
    typedef struct packed {
        rtc_time_t now;
        logic      halt;
        logic      overflow;
    } time_stat_t;

endpackage

### rtl/mbcrtc_time.sv
module mbcrtc_time (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mbcrtc_pkg::time_ctrl_t ctrl,
    output mbcrtc_pkg::time_stat_t stat
);
    import mbcrtc_pkg::*;

    rtc_time_t now_reg, now_next;
    logic      halt_reg, halt_next;
    logic      ovf_reg, ovf_next;

    rtc_time_t pre;
    rtc_time_t norm;
    logic [6:0] sec_sum;
    logic [6:0] min_sum;
    logic [5:0] hour_sum;
    logic [9:0] day_sum;
    logic       sec_c, min_c, hour_c;

    // Merge the written field into the current time
    always_comb
    begin
        pre = now_reg;
        if (!ctrl.tick)
        begin
            unique case (ctrl.sel)
                REG_SECONDS: pre.second = ctrl.data[5:0];
                REG_MINUTES: pre.minute = ctrl.data[5:0];
                REG_HOURS:   pre.hour   = ctrl.data[4:0];
                REG_DAYS:    pre.day[7:0] = ctrl.data;
                REG_DAYCTL:  pre.day[8] = ctrl.data[0];
                default:     pre = now_reg;
            endcase
        end
    end

    // Normalize with one carry per field; a day carry out means wrap
    always_comb
    begin
        sec_sum  = {1'b0, pre.second} + {6'd0, ctrl.tick};
        sec_c    = (sec_sum >= SECS_PER_MIN);
        norm.second = sec_c ? 6'(sec_sum - SECS_PER_MIN) : sec_sum[5:0];
        min_sum  = {1'b0, pre.minute} + {6'd0, sec_c};
        min_c    = (min_sum >= MINS_PER_HOUR);
        norm.minute = min_c ? 6'(min_sum - MINS_PER_HOUR) : min_sum[5:0];
        hour_sum = {1'b0, pre.hour} + {5'd0, min_c};
        hour_c   = (hour_sum >= HOURS_PER_DAY);
        norm.hour = hour_c ? 5'(hour_sum - HOURS_PER_DAY) : hour_sum[4:0];
        day_sum  = {1'b0, pre.day} + {9'd0, hour_c};
        norm.day = day_sum[8:0];
    end

    always_comb
    begin
        now_next  = now_reg;
        halt_next = halt_reg;
        ovf_next  = ovf_reg;
        if (ctrl.tick && !halt_reg)
        begin
            now_next = norm;
            if (day_sum[9])
                ovf_next = 1'b1;
        end
        else if (ctrl.write)
        begin
            if (halt_reg)
            begin
                now_next = norm;
                if (day_sum[9])
                    ovf_next = 1'b1;
            end
            if (ctrl.sel == REG_DAYCTL)
            begin
                halt_next = ctrl.data[6];
                ovf_next  = ctrl.data[7];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg  <= '0;
            halt_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            now_reg  <= now_next;
            halt_reg <= halt_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign stat.now      = now_reg;
    assign stat.halt     = halt_reg;
    assign stat.overflow = ovf_reg;

endmodule

### rtl/cartridge_rtc_latch_registers.sv
// Channel | Direction | Handshake           | Payload
// cmd     | in        | cmd_valid/cmd_stall | cmd_t: opcode, data_byte
// rsp     | out       | rsp_valid/rsp_stall | rsp_t: read_data, select_error
//
// One transaction per cycle sustained while rsp_stall stays low: each command is captured
// in the command register, executed in one pass through the time counter and register
// logic, and its response is registered in the response register.
// Reset clears the time, the latch registers, the flags and the selection; the
// clock starts disabled. A stalled response holds, and cmd_stall rises only while
// the held command cannot move into the response register.
module cartridge_rtc_latch_registers (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  mbcrtc_pkg::cmd_t cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output mbcrtc_pkg::rsp_t rsp
);
    import mbcrtc_pkg::*;

    // Command register
    logic       cmd_valid_reg;
    cmd_t       cmd_reg;
    // Response register
    logic       rsp_valid_reg;
    rsp_t       rsp_reg, rsp_next;
    // Bus-visible state
    logic [2:0] sel_reg, sel_next;
    logic       enable_reg, enable_next;
    logic [7:0] prev_latch_reg, prev_latch_next;
    rtc_time_t  latched_reg, latched_next;

    logic       advance;
    time_ctrl_t tctrl;
    time_stat_t tstat;
    logic [7:0] rd_value;
    logic [7:0] rd_mask;

    // Execute the held command when the response register can take its result
    assign advance   = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = cmd_valid_reg && !advance;

    assign tctrl.tick  = advance && (cmd_reg.opcode == OP_TICK);
    assign tctrl.write = advance && (cmd_reg.opcode == OP_WRITE) && enable_reg;
    assign tctrl.sel   = sel_reg;
    assign tctrl.data  = cmd_reg.data_byte;

    mbcrtc_time u_time (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tctrl),
        .stat  (tstat)
    );

    // Mux the selected latch register
    always_comb
    begin
        unique case (sel_reg)
            REG_SECONDS:
            begin
                rd_value = {2'b00, latched_reg.second};
                rd_mask  = MASK_SECONDS;
            end
            REG_MINUTES:
            begin
                rd_value = {2'b00, latched_reg.minute};
                rd_mask  = MASK_MINUTES;
            end
            REG_HOURS:
            begin
                rd_value = {3'b000, latched_reg.hour};
                rd_mask  = MASK_HOURS;
            end
            REG_DAYS:
            begin
                rd_value = latched_reg.day[7:0];
                rd_mask  = MASK_DAYS;
            end
            default:
            begin
                // Day control: overflow, halt, day MSB
                rd_value = {tstat.overflow, tstat.halt, 5'd0, latched_reg.day[8]};
                rd_mask  = MASK_DAYCTL;
            end
        endcase
    end

    always_comb
    begin
        rsp_next        = '0;
        sel_next        = sel_reg;
        enable_next     = enable_reg;
        prev_latch_next = prev_latch_reg;
        latched_next    = latched_reg;
        unique case (cmd_reg.opcode)
            OP_SELECT:
            begin
                // Reject an out-of-range index and keep the selection
                if (cmd_reg.data_byte < NUM_REGS)
                    sel_next = cmd_reg.data_byte[2:0];
                else
                    rsp_next.select_error = 1'b1;
            end
            OP_ENABLE:
                enable_next = (cmd_reg.data_byte != 8'd0);
            OP_LATCH:
            begin
                // Copy the running time on a 0-then-1 sequence
                if (prev_latch_reg == 8'd0 && cmd_reg.data_byte == 8'd1)
                    latched_next = tstat.now;
                prev_latch_next = cmd_reg.data_byte;
            end
            OP_READ:
                rsp_next.read_data = enable_reg ? (rd_value & rd_mask) : READ_DISABLED;
            default:
                rsp_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            sel_reg        <= '0;
            enable_reg     <= 1'b0;
            prev_latch_reg <= '0;
            latched_reg    <= '0;
        end
        else
        begin
            if (!cmd_stall)
                cmd_valid_reg <= cmd_valid;
            if (advance)
            begin
                rsp_valid_reg  <= 1'b1;
                sel_reg        <= sel_next;
                enable_reg     <= enable_next;
                prev_latch_reg <= prev_latch_next;
                latched_reg    <= latched_next;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
            cmd_reg <= cmd;
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### bench/cartridge_rtc_latch_registers_tb.sv
`timescale 1ns / 100ps

module cartridge_rtc_latch_registers_tb;

    import mbcrtc_pkg::*;

    // Opcodes the block leaves unused; they must come back as all zeros
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned MAX_DAY      = 511;
    localparam int unsigned DAY_SPAN     = (MAX_DAY + 1) * SECS_PER_DAY;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;

    localparam logic PIN  = 1'b1;   // row carries a typed-in response
    localparam logic FREE = 1'b0;   // row is checked against the predictor

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       pinned;
        logic [7:0] read_data;
        logic       select_error;
    } stim_row_t;

    typedef enum int {
        SEQ_SET_TIME,
        SEQ_TICKS,
        SEQ_LATCH_READ,
        SEQ_NOISE,
        SEQ_BAD_SELECT,
        SEQ_STRAY_WRITE,
        SEQ_DISABLED_READ
    } seq_kind_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Predicted clock state
    logic [25:0] rtc_seconds;
    logic [5:0]  snap_sec;
    logic [5:0]  snap_min;
    logic [4:0]  snap_hour;
    logic [7:0]  snap_day_lo;
    logic        snap_day_msb;
    logic        halted;
    logic        day_carry;
    logic [7:0]  last_latch_byte;
    logic [2:0]  reg_sel;
    logic        rtc_on;

    logic [7:0] field_mask [5] = '{MASK_SECONDS, MASK_MINUTES, MASK_HOURS, MASK_DAYS,
                                   MASK_DAYCTL};
    // Largest in-range value of each time field; used to park the count near a wrap
    logic [7:0] field_top [4] = '{8'd59, 8'd59, 8'd23, 8'hFF};

    rsp_t expected_rsp [$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   live_items = 0;
    int   stall_left = 0;

    // Directed sweep: disabled access, bad selects, halt, field extremes, wrap on
    // rebuild, tick while halted, latch sequence, unused opcodes
    stim_row_t directed_rows [27] = '{
        '{OP_READ,    8'h00,              PIN,  READ_DISABLED, 1'b0},
        '{OP_WRITE,   8'h40,              PIN,  8'h00,         1'b0},
        '{OP_SELECT,  8'h07,              PIN,  8'h00,         1'b1},
        '{OP_SELECT,  8'hFF,              PIN,  8'h00,         1'b1},
        '{OP_ENABLE,  8'h80,              PIN,  8'h00,         1'b0},
        '{OP_SELECT,  {5'd0, REG_DAYCTL}, PIN,  8'h00,         1'b0},
        '{OP_READ,    8'h00,              PIN,  8'h00,         1'b0},
        '{OP_WRITE,   8'h40,              FREE, 8'h00,         1'b0},
        '{OP_TICK,    8'h00,              FREE, 8'h00,         1'b0},
        '{OP_SELECT,  {5'd0, REG_DAYS},   FREE, 8'h00,         1'b0},
        '{OP_WRITE,   8'hFF,              FREE, 8'h00,         1'b0},
        '{OP_SELECT,  {5'd0, REG_DAYCTL}, FREE, 8'h00,         1'b0},
        '{OP_WRITE,   8'hC1,              FREE, 8'h00,         1'b0},
        '{OP_SELECT,  {5'd0, REG_HOURS},  FREE, 8'h00,         1'b0},
        '{OP_WRITE,   8'h1F,              FREE, 8'h00,         1'b0},
        '{OP_SELECT,  {5'd0, REG_SECONDS},FREE, 8'h00,         1'b0},
        '{OP_WRITE,   8'h3F,              FREE, 8'h00,         1'b0},
        '{OP_SELECT,  {5'd0, REG_DAYCTL}, FREE, 8'h00,         1'b0},
        '{OP_WRITE,   8'h01,              FREE, 8'h00,         1'b0},
        '{OP_TICK,    8'hFF,              FREE, 8'h00,         1'b0},
        '{OP_LATCH,   8'h00,              FREE, 8'h00,         1'b0},
        '{OP_LATCH,   8'h01,              FREE, 8'h00,         1'b0},
        '{OP_READ,    8'hFF,              FREE, 8'h00,         1'b0},
        '{OP_SPARE_A, 8'hAA,              PIN,  8'h00,         1'b0},
        '{OP_SPARE_B, 8'h55,              PIN,  8'h00,         1'b0},
        '{OP_ENABLE,  8'h00,              PIN,  8'h00,         1'b0},
        '{OP_READ,    8'h00,              PIN,  READ_DISABLED, 1'b0}
    };

    cartridge_rtc_latch_registers dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Split the running count into one register field
    function automatic logic [7:0] count_field(input logic [2:0] idx);
        int unsigned days;
        days = rtc_seconds / SECS_PER_DAY;
        case (idx)
            REG_SECONDS: return 8'(rtc_seconds % SECS_PER_MIN);
            REG_MINUTES: return 8'((rtc_seconds / SECS_PER_MIN) % MINS_PER_HOUR);
            REG_HOURS:   return 8'((rtc_seconds / 3600) % HOURS_PER_DAY);
            REG_DAYS:    return 8'(days & 8'hFF);
            default:     return 8'((days >> 8) & 1);
        endcase
    endfunction

    // Fold the count back into 512 days and raise the carry on a wrap
    function automatic void wrap_count();
        if (rtc_seconds / SECS_PER_DAY > MAX_DAY)
        begin
            rtc_seconds = 26'(rtc_seconds % DAY_SPAN);
            day_carry = 1'b1;
        end
    endfunction

    // Advance the predicted clock by one transaction and return its response
    task automatic rtc_step(input cmd_t c, output rsp_t r);
        logic [2:0]  sel;
        logic [7:0]  fld [5];
        logic [7:0]  v;
        int unsigned total;
        sel = (reg_sel < NUM_REGS) ? reg_sel : REG_SECONDS;
        r = '0;
        case (c.opcode)
            OP_SELECT:
                if (c.data_byte < NUM_REGS)
                    reg_sel = c.data_byte[2:0];
                else
                    r.select_error = 1'b1;
            OP_ENABLE:
                rtc_on = (c.data_byte != 8'h00);
            OP_LATCH:
            begin
                // Copy the count only on a 0 then 1 sequence
                if (last_latch_byte == 8'h00 && c.data_byte == 8'h01)
                begin
                    snap_sec     = 6'(count_field(REG_SECONDS));
                    snap_min     = 6'(count_field(REG_MINUTES));
                    snap_hour    = 5'(count_field(REG_HOURS));
                    snap_day_lo  = count_field(REG_DAYS);
                    snap_day_msb = 1'(count_field(REG_DAYCTL));
                end
                last_latch_byte = c.data_byte;
            end
            OP_READ:
                if (!rtc_on)
                    r.read_data = READ_DISABLED;
                else
                begin
                    case (sel)
                        REG_SECONDS: v = 8'(snap_sec);
                        REG_MINUTES: v = 8'(snap_min);
                        REG_HOURS:   v = 8'(snap_hour);
                        REG_DAYS:    v = snap_day_lo;
                        default:     v = {day_carry, halted, 5'd0, snap_day_msb};
                    endcase
                    r.read_data = v & field_mask[sel];
                end
            OP_WRITE:
                if (rtc_on)
                begin
                    // Rebuild the count only while halted
                    if (halted)
                    begin
                        for (int i = 0; i < 5; i++)
                            fld[i] = count_field(3'(i));
                        fld[sel] = c.data_byte & field_mask[sel];
                        total = int'(fld[0]) + int'(fld[1]) * 60 + int'(fld[2]) * 3600
                              + int'({fld[4][0], fld[3]}) * SECS_PER_DAY;
                        rtc_seconds = 26'(total);
                        wrap_count();
                    end
                    // Day control flags override whatever the rebuild raised
                    if (sel == REG_DAYCTL)
                    begin
                        halted = c.data_byte[6];
                        day_carry = c.data_byte[7];
                    end
                end
            OP_TICK:
                if (!halted)
                begin
                    rtc_seconds = rtc_seconds + 26'd1;
                    wrap_count();
                end
            default:
                ;
        endcase
    endtask

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        if ($urandom_range(99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one transaction, hold it until accepted, record its prediction,
    // then drop valid for a random gap
    task automatic send_cmd(input logic [2:0] op, input logic [7:0] data,
                            input logic pinned = FREE, input rsp_t pinned_rsp = '0);
        cmd_t c;
        rsp_t want;
        int   gap;
        c.opcode = op;
        c.data_byte = data;
        cmd <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        rtc_step(c, want);
        expected_rsp.push_back(pinned ? pinned_rsp : want);
        if (op <= OP_TICK)
            live_items++;
        // Every third window of the cycle count runs back to back
        if (((cycle_count / 400) % 3) == 2 || $urandom_range(99) < 60)
            gap = 0;
        else
            gap = pick_idle_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Response stall: random bursts, with a quiet stretch in every third window
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else if (((cycle_count / 400) % 3) == 1 || $urandom_range(99) >= 20)
            rsp_stall <= 1'b0;
        else
        begin
            rsp_stall <= 1'b1;
            stall_left = pick_idle_len() - 1;
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response with none pending: read_data=%h select_error=%b",
                       rsp.read_data, rsp.select_error);
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
                    error_count++;
                end
                if (rsp.select_error !== want.select_error)
                begin
                    $error("select_error: expected %b, got %b",
                           want.select_error, rsp.select_error);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        seq_kind_e  kind;
        int         roll;
        int         n;
        logic       near_end;
        logic [2:0] fld_idx;
        logic [7:0] value;

        // Predictor starts from the reset state
        rtc_seconds = '0;
        snap_sec = '0;
        snap_min = '0;
        snap_hour = '0;
        snap_day_lo = '0;
        snap_day_msb = 1'b0;
        halted = 1'b0;
        day_carry = 1'b0;
        last_latch_byte = '0;
        reg_sel = REG_SECONDS;
        rtc_on = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pinned,
                     '{directed_rows[i].read_data, directed_rows[i].select_error});
        live_items = 0;

        // Random part: mostly well-formed bus sequences with random content
        while (live_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                kind = SEQ_SET_TIME;
            else if (roll < 52)
                kind = SEQ_TICKS;
            else if (roll < 76)
                kind = SEQ_LATCH_READ;
            else if (roll < 86)
                kind = SEQ_NOISE;
            else if (roll < 90)
                kind = SEQ_BAD_SELECT;
            else if (roll < 95)
                kind = SEQ_STRAY_WRITE;
            else
                kind = SEQ_DISABLED_READ;

            case (kind)
                SEQ_SET_TIME:
                begin
                    // Enable, halt, load fields, release the halt
                    send_cmd(OP_ENABLE, 8'($urandom_range(1, 255)));
                    send_cmd(OP_SELECT, {5'd0, REG_DAYCTL});
                    send_cmd(OP_WRITE, {1'($urandom), 1'b1, 6'($urandom)});
                    near_end = ($urandom_range(99) < 35);
                    n = near_end ? 4 : $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                    begin
                        fld_idx = near_end ? 3'(k) : 3'($urandom_range(0, 3));
                        if (near_end)
                            value = field_top[fld_idx[1:0]] - 8'($urandom_range(0, 3));
                        else if ($urandom_range(1) == 1)
                            value = field_top[fld_idx[1:0]];
                        else
                            value = 8'($urandom_range(255));
                        send_cmd(OP_SELECT, {5'd0, fld_idx});
                        send_cmd(OP_WRITE, value);
                    end
                    send_cmd(OP_SELECT, {5'd0, REG_DAYCTL});
                    send_cmd(OP_WRITE, {1'($urandom), 1'b0, 5'($urandom),
                                        near_end ? 1'b1 : 1'($urandom)});
                end
                SEQ_TICKS:
                    repeat ($urandom_range(1, 24))
                        send_cmd(OP_TICK, 8'($urandom_range(255)));
                SEQ_LATCH_READ:
                begin
                    // Mostly a clean 0 then 1; sometimes a stray first byte
                    if ($urandom_range(99) < 80)
                        send_cmd(OP_LATCH, 8'h00);
                    else
                        send_cmd(OP_LATCH, 8'($urandom_range(255)));
                    send_cmd(OP_LATCH, 8'h01);
                    repeat ($urandom_range(1, 5))
                    begin
                        send_cmd(OP_SELECT, 8'($urandom_range(0, 4)));
                        send_cmd(OP_READ, 8'($urandom_range(255)));
                    end
                end
                SEQ_NOISE:
                    repeat ($urandom_range(1, 4))
                        send_cmd(3'($urandom_range(7)), 8'($urandom_range(255)));
                SEQ_BAD_SELECT:
                begin
                    send_cmd(OP_SELECT, 8'($urandom_range(5, 255)));
                    send_cmd(OP_READ, 8'($urandom_range(255)));
                end
                SEQ_STRAY_WRITE:
                begin
                    send_cmd(OP_SELECT, 8'($urandom_range(0, 4)));
                    send_cmd(OP_WRITE, 8'($urandom_range(255)));
                end
                default:
                begin
                    send_cmd(OP_ENABLE, 8'h00);
                    send_cmd(OP_READ, 8'($urandom_range(255)));
                    send_cmd(OP_WRITE, 8'($urandom_range(255)));
                    send_cmd(OP_ENABLE, 8'($urandom_range(1, 255)));
                end
            endcase
        end

        // Drain: wait for every pending response, then let the pipeline settle
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
